FILE: src/rational_arithmetic_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the rational arithmetic unit
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define RAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rau check failed");

// Next-cycle implication, sampled on clk, off while rst is high
`define RAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rau check failed");

`endif

FILE: src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared constants and types of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rau_pkg;

  localparam int DATA_WIDTH_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CMD_W           = 3;

  // operation codes
  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EQ    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LT    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_VALID = 3'd6;

  // classification attached by the front end to each queued beat
  typedef struct packed {
    logic arith;    // cross products needed
    logic reduce;   // a GCD reduction follows
    logic bn_zero;  // second numerator is zero
    logic aden_nz;  // first denominator is nonzero
  } cls_t;

  localparam int CLS_W = $bits(cls_t);

endpackage

FILE: src/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dsr;
  logic [W:0]    trial;
  logic          fits;

  // shift in the next dividend bit and test against the divisor
  always_comb begin
    trial = {rem, quo[W-1]};
    fits  = (trial >= {1'b0, dsr});
  end

  // control: run W steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[W-2:0], fits};
      rem <= fits ? W'(trial - {1'b0, dsr}) : trial[W-1:0];
    end
  end

endmodule

FILE: src/rau_fifo.sv
// ----------------------------------------------------------------------------
// rau_fifo
// Small register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             nempty,
  output logic [WIDTH-1:0] dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign full   = (count == NW'(DEPTH));
  assign nempty = (count != '0);
  assign dout   = mem[rd_ptr];

  // store beats
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/rau_front.sv
// ----------------------------------------------------------------------------
// rau_front
// Accepts input beats, classifies the operation and queues the beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_front #(
  parameter int W = 32
) (
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rau_pkg::CMD_W-1:0]  cmd,
  input  logic [W-1:0]               a_num,
  input  logic [W-1:0]               a_den,
  input  logic [W-1:0]               b_num,
  input  logic [W-1:0]               b_den,
  input  logic                       q_full,
  output logic                       q_push,
  output logic [rau_pkg::CMD_W+rau_pkg::CLS_W+4*W-1:0] q_din
);
  import rau_pkg::*;

  cls_t cls;

  // decode the operation
  always_comb begin
    cls.arith   = (cmd inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV});
    cls.reduce  = (cmd inside {CMD_ADD, CMD_MUL, CMD_EQ, CMD_LT});
    cls.bn_zero = (b_num == '0);
    cls.aden_nz = (a_den != '0);
  end

  // hand the beat to the queue
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_din    = {cmd, cls, a_num, a_den, b_num, b_den};

endmodule

FILE: src/rau_back.sv
// ----------------------------------------------------------------------------
// rau_back
// Sequencer that carries out one queued operation: cross products on a
// shared multiplier, Euclid reduction on a shared divider, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_back #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_nempty,
  input  logic [rau_pkg::CMD_W+rau_pkg::CLS_W+4*W-1:0] q_dout,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [W-1:0]        res_num,
  output logic [W-1:0]        res_den,
  output logic                flag
);
  import rau_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MUL  = 9'b000000010,
    ST_COMB = 9'b000000100,
    ST_GCD  = 9'b000001000,
    ST_GCDW = 9'b000010000,
    ST_QN   = 9'b000100000,
    ST_QD   = 9'b001000000,
    ST_RED  = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? W'(-v) : v;
  endfunction

  function automatic logic [W-1:0] sneg(input logic [W-1:0] v, input logic s);
    sneg = s ? W'(-v) : v;
  endfunction

  state_t         state;
  logic [CMD_W-1:0] op;
  cls_t           cls;
  cls_t           q_cls;
  logic [W-1:0]   an, ad, bn, bd;
  logic [W-1:0]   p0, p1, p2;
  logic [W-1:0]   fn, fd, x, y, g;
  logic [W-1:0]   rn, rd, xn, xd;
  logic           which;
  logic [1:0]     mstep;
  logic [W-1:0]   dnum, dden;
  logic           dflag;

  logic [W-1:0]   mul_a, mul_b, prod;
  logic           last_step;
  logic           x_neg, y_neg, lt_ok;
  logic           div_start, div_done;
  logic [W-1:0]   div_a, div_b, div_q, div_r;

  rau_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  assign q_pop = (state == ST_IDLE) && q_nempty;
  assign q_cls = cls_t'(q_dout[4*W +: CLS_W]);

  // sign cases of the less-than test on the two reduced operands
  always_comb begin
    x_neg = xd[W-1];
    y_neg = rd[W-1];
    lt_ok = (xd != '0) && (rd != '0) && !(x_neg && y_neg);
  end

  // select multiplier operands by operation and step
  always_comb begin
    mul_a = an;
    mul_b = bd;
    case (op)
      CMD_ADD, CMD_SUB: begin
        case (mstep)
          2'd0:    begin mul_a = an; mul_b = bd; end
          2'd1:    begin mul_a = ad; mul_b = bn; end
          default: begin mul_a = ad; mul_b = bd; end
        endcase
      end
      CMD_MUL: begin
        mul_a = (mstep == 2'd0) ? an : ad;
        mul_b = (mstep == 2'd0) ? bn : bd;
      end
      CMD_DIV: begin
        mul_a = (mstep == 2'd0) ? an : ad;
        mul_b = (mstep == 2'd0) ? bd : bn;
      end
      CMD_LT: begin
        mul_a = (mstep == 2'd0) ? sneg(xn, x_neg) : sneg(xd, x_neg);
        mul_b = (mstep == 2'd0) ? sneg(rd, y_neg) : sneg(rn, y_neg);
      end
      default: begin
        mul_a = an;
        mul_b = bd;
      end
    endcase
    prod      = W'(mul_a * mul_b);
    last_step = (op inside {CMD_ADD, CMD_SUB}) ? (mstep == 2'd2) : (mstep == 2'd1);
  end

  // issue divider work
  always_comb begin
    div_start = 1'b0;
    div_a     = mag(x);
    div_b     = mag(y);
    case (state)
      ST_GCD: begin
        if (y != '0) begin
          div_start = 1'b1;
        end else if (x != '0) begin
          div_start = 1'b1;
          div_a     = mag(fn);
          div_b     = mag(x);
        end
      end
      ST_QN: begin
        div_a     = mag(fd);
        div_b     = mag(g);
        div_start = div_done;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // raise valid when a result is loaded, drop it once the beat is taken
      if ((state == ST_DONE) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_nempty) begin
            {op, cls, an, ad, bn, bd} <= q_dout;
            which <= 1'b0;
            mstep <= 2'd0;
            dnum  <= '0;
            dden  <= '0;
            if (q_cls.arith) begin
              dflag <= 1'b0;
              state <= ST_MUL;
            end else if (q_cls.reduce) begin
              dflag <= 1'b0;
              fn    <= q_dout[3*W +: W];
              fd    <= q_dout[2*W +: W];
              x     <= q_dout[3*W +: W];
              y     <= q_dout[2*W +: W];
              state <= ST_GCD;
            end else begin
              dflag <= (q_dout[4*W + CLS_W +: CMD_W] == CMD_VALID)
                       && q_cls.aden_nz;
              state <= ST_DONE;
            end
          end
        end
        ST_MUL: begin
          case (mstep)
            2'd0:    p0 <= prod;
            2'd1:    p1 <= prod;
            default: p2 <= prod;
          endcase
          mstep <= mstep + 2'd1;
          if (last_step) begin
            state <= ST_COMB;
          end
        end
        ST_COMB: begin
          case (op)
            CMD_ADD: begin
              fn    <= p0 + p1;
              fd    <= p2;
              x     <= p0 + p1;
              y     <= p2;
              state <= ST_GCD;
            end
            CMD_MUL: begin
              fn    <= p0;
              fd    <= p1;
              x     <= p0;
              y     <= p1;
              state <= ST_GCD;
            end
            CMD_SUB: begin
              dnum  <= p0 - p1;
              dden  <= p2;
              state <= ST_DONE;
            end
            CMD_DIV: begin
              dnum  <= cls.bn_zero ? '0 : p0;
              dden  <= cls.bn_zero ? '0 : p1;
              state <= ST_DONE;
            end
            CMD_LT: begin
              dflag <= lt_ok && ($signed(p0) < $signed(p1));
              state <= ST_DONE;
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end
        ST_GCD: begin
          if (y != '0) begin
            state <= ST_GCDW;
          end else if (x != '0) begin
            g     <= x;
            state <= ST_QN;
          end else begin
            rn    <= '0;
            rd    <= '0;
            state <= ST_RED;
          end
        end
        ST_GCDW: begin
          // remainder takes the sign of the dividend
          if (div_done) begin
            x     <= y;
            y     <= sneg(div_r, x[W-1]);
            state <= ST_GCD;
          end
        end
        ST_QN: begin
          if (div_done) begin
            rn    <= sneg(div_q, fn[W-1] ^ g[W-1]);
            state <= ST_QD;
          end
        end
        ST_QD: begin
          if (div_done) begin
            rd    <= sneg(div_q, fd[W-1] ^ g[W-1]);
            state <= ST_RED;
          end
        end
        ST_RED: begin
          if ((op inside {CMD_EQ, CMD_LT}) && !which) begin
            xn    <= rn;
            xd    <= rd;
            which <= 1'b1;
            fn    <= bn;
            fd    <= bd;
            x     <= bn;
            y     <= bd;
            state <= ST_GCD;
          end else if (op == CMD_EQ) begin
            dflag <= (xn == rn) && (xd == rd);
            state <= ST_DONE;
          end else if (op == CMD_LT) begin
            mstep <= 2'd0;
            state <= ST_MUL;
          end else begin
            dnum  <= rn;
            dden  <= rd;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!out_valid || !out_stall)) begin
      res_num <= dnum;
      res_den <= dden;
      flag    <= dflag;
    end
  end

endmodule

FILE: src/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Rational add, subtract, multiply, divide, compare and validity test; add,
// multiply and compare use GCD reduction.
// Input channel: in_valid / in_stall with cmd, a_num, a_den, b_num, b_den.
// A beat is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with res_num, res_den, flag; one
// result beat for every input beat, in order.
// A front end decodes each beat into a small queue (QUEUE_DEPTH entries);
// a back end sequencer works one item at a time on a shared multiplier and
// a bit-serial divider. Valid and unknown codes go straight to the result;
// subtract and divide use only the cross products; add, multiply, equal and
// less-than also run the Euclid remainder chain, so their time depends on it.
// A new item is taken only after the previous result is loaded; for reduced
// operations the divider work dominates the time per item.
// A result waiting under out_stall holds; the queue keeps accepting until
// full, then in_stall rises. Reset empties the queue and clears out_valid;
// the result register itself is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_arithmetic_unit #(
  parameter int DATA_WIDTH  = rau_pkg::DATA_WIDTH_DEF,
  parameter int QUEUE_DEPTH = rau_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rau_pkg::CMD_W-1:0]     cmd,
  input  logic signed [DATA_WIDTH-1:0]  a_num,
  input  logic signed [DATA_WIDTH-1:0]  a_den,
  input  logic signed [DATA_WIDTH-1:0]  b_num,
  input  logic signed [DATA_WIDTH-1:0]  b_den,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]  res_num,
  output logic signed [DATA_WIDTH-1:0]  res_den,
  output logic                          flag
);
  import rau_pkg::*;

  localparam int QW = CMD_W + CLS_W + 4 * DATA_WIDTH;

  logic          q_push, q_full, q_pop, q_nempty;
  logic [QW-1:0] q_din, q_dout;
  logic [DATA_WIDTH-1:0] rnum, rden;

  rau_front #(.W(DATA_WIDTH)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .a_num    (a_num),
    .a_den    (a_den),
    .b_num    (b_num),
    .b_den    (b_den),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_din    (q_din)
  );

  rau_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .din    (q_din),
    .full   (q_full),
    .pop    (q_pop),
    .nempty (q_nempty),
    .dout   (q_dout)
  );

  rau_back #(.W(DATA_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_nempty  (q_nempty),
    .q_dout    (q_dout),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_num   (rnum),
    .res_den   (rden),
    .flag      (flag)
  );

  assign res_num = rnum;
  assign res_den = rden;

endmodule

FILE: src/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_assert.svh"

module rau_checker #(
  parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [DATA_WIDTH-1:0] res_num,
  input logic [DATA_WIDTH-1:0] res_den,
  input logic                  flag
);

  logic [7:0] pending;

  // track items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({in_valid && !in_stall, out_valid && !out_stall})
        2'b10:   pending <= pending + 8'd1;
        2'b01:   pending <= pending - 8'd1;
        default: pending <= pending;
      endcase
    end
  end

  `RAU_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(res_num))
  `RAU_ASSERT_IMP(a_flag_zero, out_valid && flag, res_num == '0 && res_den == '0)
  `RAU_ASSERT_IMP(a_no_orphan, out_valid, pending != 8'd0)

endmodule

bind rational_arithmetic_unit rau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rau_checker (.*);

FILE: verif/rational_arithmetic_unit_test.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction pairs with every operation code, predicts each result with
// a local model of the wrapped cross products and the truncating GCD, and
// checks every result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_arithmetic_unit_test;
  import rau_pkg::*;

  localparam int W = 32;
  localparam logic [CMD_W-1:0] CMD_UNDEF = 3'd7;

  typedef logic signed [W-1:0] word_t;
  typedef struct packed {
    word_t num;
    word_t den;
    logic  flag;
  } answer_t;
  typedef struct {
    word_t num;
    word_t den;
  } fraction_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] cmd = '0;
  word_t a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  word_t res_num, res_den;
  logic flag;

  answer_t pending_answers[$];
  int errors = 0;
  int burst_left = 0;
  int stall_mode = 0;

  rational_arithmetic_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_num(res_num), .res_den(res_den), .flag(flag)
  );

  always #5 clk = ~clk;

  // truncating quotient; wraps on most negative over minus one
  function automatic word_t trunc_div(word_t x, word_t y);
    logic [W-1:0] mx, my, q;
    begin
      mx = x[W-1] ? -x : x;
      my = y[W-1] ? -y : y;
      q = mx / my;
      return (x[W-1] != y[W-1]) ? -q : q;
    end
  endfunction

  // truncating remainder, sign of the dividend
  function automatic word_t trunc_rem(word_t x, word_t y);
    logic [W-1:0] mx, my, r;
    begin
      mx = x[W-1] ? -x : x;
      my = y[W-1] ? -y : y;
      r = mx % my;
      return x[W-1] ? -r : r;
    end
  endfunction

  function automatic fraction_t reduce_fraction(fraction_t f);
    word_t x, y, r;
    fraction_t o;
    begin
      x = f.num;
      y = f.den;
      while (y != 0) begin
        r = trunc_rem(x, y);
        x = y;
        y = r;
      end
      if (x == 0) begin
        o.num = 0;
        o.den = 0;
      end else begin
        o.num = trunc_div(f.num, x);
        o.den = trunc_div(f.den, x);
      end
      return o;
    end
  endfunction

  function automatic logic fraction_less(fraction_t x, fraction_t y);
    word_t pa, pb;
    begin
      x = reduce_fraction(x);
      y = reduce_fraction(y);
      if (x.den > 0 && y.den > 0) begin
        pa = x.num * y.den;
        pb = x.den * y.num;
      end else if (x.den < 0 && y.den > 0) begin
        pa = (-x.num) * y.den;
        pb = (-x.den) * y.num;
      end else if (y.den < 0 && x.den > 0) begin
        pa = x.num * (-y.den);
        pb = x.den * (-y.num);
      end else begin
        return 1'b0;
      end
      return pa < pb;
    end
  endfunction

  function automatic answer_t predict_answer(logic [CMD_W-1:0] op, word_t an, word_t ad,
                                             word_t bn, word_t bd);
    answer_t ans;
    fraction_t fa, fb, fr;
    begin
      ans = '0;
      fa.num = an; fa.den = ad;
      fb.num = bn; fb.den = bd;
      case (op)
        CMD_ADD: begin
          fr.num = an * bd + ad * bn;
          fr.den = ad * bd;
          fr = reduce_fraction(fr);
          ans.num = fr.num; ans.den = fr.den;
        end
        CMD_SUB: begin
          ans.num = an * bd - ad * bn;
          ans.den = ad * bd;
        end
        CMD_MUL: begin
          fr.num = an * bn;
          fr.den = ad * bd;
          fr = reduce_fraction(fr);
          ans.num = fr.num; ans.den = fr.den;
        end
        CMD_DIV: begin
          if (bn != 0) begin
            ans.num = an * bd;
            ans.den = ad * bn;
          end
        end
        CMD_EQ: begin
          fa = reduce_fraction(fa);
          fb = reduce_fraction(fb);
          ans.flag = (fa.num == fb.num) && (fa.den == fb.den);
        end
        CMD_LT: ans.flag = fraction_less(fa, fb);
        CMD_VALID: ans.flag = (ad != 0);
        default: ;
      endcase
      return ans;
    end
  endfunction

  // send one beat; sender works in bursts with random gaps
  task automatic send_fraction_pair(logic [CMD_W-1:0] op, word_t an, word_t ad,
                                    word_t bn, word_t bd);
    begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 2) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 40)) @(negedge clk);
        end
      end
      burst_left--;
      cmd <= op; a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
      in_valid <= 1'b1;
      pending_answers.push_back(predict_answer(op, an, ad, bn, bd));
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
    end
  endtask

  function automatic word_t random_word();
    case ($urandom_range(0, 7))
      0: return word_t'($urandom_range(0, 4)) - 2;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2, 3: return word_t'($urandom_range(0, 200)) - 100;
      4: return word_t'($urandom_range(0, 20000)) - 10000;
      default: return word_t'($urandom);
    endcase
  endfunction

  // drop valid and hold until every expected result has come back
  task automatic wait_drained();
    begin
      in_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clk);
    end
  endtask

  task automatic test_directed();
    logic [CMD_W-1:0] op;
    begin
      for (int i = 0; i < 8; i++) begin
        op = CMD_W'(i);
        send_fraction_pair(op, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, -1);
      end
      // zero over zero reductions, divide by zero numerator, overflow on wrap
      send_fraction_pair(CMD_ADD, 0, 0, 0, 5);
      send_fraction_pair(CMD_MUL, 32'sh80000000, 1, -1, 1);
      send_fraction_pair(CMD_DIV, 3, 4, 0, 7);
      send_fraction_pair(CMD_EQ, 0, 0, 0, 0);
      send_fraction_pair(CMD_EQ, 2, 4, -1, -2);
      send_fraction_pair(CMD_LT, 1, -2, 1, 3);
      send_fraction_pair(CMD_LT, 1, 3, 1, -2);
      send_fraction_pair(CMD_LT, 1, -2, 1, -3);
      send_fraction_pair(CMD_LT, 1, 0, 1, 3);
      send_fraction_pair(CMD_VALID, 5, 0, 1, 1);
      send_fraction_pair(CMD_SUB, -1, -1, -1, -1);
      send_fraction_pair(CMD_ADD, 1, 2, 1, 3);
    end
  endtask

  task automatic test_random(int count);
    logic [CMD_W-1:0] op;
    begin
      for (int i = 0; i < count; i++) begin
        op = ($urandom_range(0, 30) == 0) ? CMD_UNDEF : CMD_W'($urandom_range(0, 6));
        send_fraction_pair(op, random_word(), random_word(), random_word(), random_word());
      end
    end
  endtask

  // receiver stall pattern: alternate between free, random and heavy stalling
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d flag %0b", $time, res_num, res_den, flag);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (res_num !== want.num) begin
          $display("%0t: res_num expected %0d actual %0d", $time, want.num, res_num);
          errors++;
        end
        if (res_den !== want.den) begin
          $display("%0t: res_den expected %0d actual %0d", $time, want.den, res_den);
          errors++;
        end
        if (flag !== want.flag) begin
          $display("%0t: flag expected %0b actual %0b", $time, want.flag, flag);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();
    test_random(700);
    wait_drained();
    test_random(730);
    wait_drained();
    repeat (50) @(negedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hold-off for the slowest run: ~1500 items with stalls
  initial begin
    #200ms;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: rational_arithmetic_unit.f
+incdir+src
src/rau_pkg.sv
src/rau_div.sv
src/rau_fifo.sv
src/rau_front.sv
src/rau_back.sv
src/rational_arithmetic_unit.sv
src/rau_checker.sv
verif/rational_arithmetic_unit_test.sv
